>>> rtl/q16aru_pkg.sv
// Shared types for the fixed-point arithmetic unit.
`default_nettype none
package q16aru_pkg;
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_SQRT = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_MFIN,
        ST_SQSCAN,
        ST_SQTRY,
        ST_WRITE
    } state_t;

    typedef enum logic [1:0] {
        MODE_MUL,
        MODE_DIV,
        MODE_SQLO,
        MODE_SQHI
    } mode_t;
endpackage
`default_nettype wire

>>> rtl/q16_16_arithmetic_unit.sv
// Top level: bit-serial fixed-point add, subtract, multiply, divide and square root.
`default_nettype none
// One item in, one result out. Add, subtract and unused opcodes go straight to the write
// state. Multiply: a shift-add multiplier retires one multiplier bit per cycle.
// Divide: a restoring divider forms the 32-bit reciprocal one quotient bit per cycle,
// then the same multiplier runs. Square root runs one multiply per result bit
// (FRAC_BITS trials below one, up to (32-FRAC_BITS)/2+FRAC_BITS trials above one), each
// trial passing the try, multiply and finish states, after a start-bit scan above one.
// A finished result waits in the output register; new items are taken once it is written there.
module q16_16_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // opcode[2:0], operand_a[34:3], operand_b[66:35]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata   // result[31:0], divide_by_zero[32]
);
    localparam logic [31:0] ONE_VAL   = 32'(1) << FRAC_BITS;
    localparam int          START_BIT = ((32 - FRAC_BITS) >> 1) + FRAC_BITS - 1;

    q16aru_pkg::state_t state_reg, state_next;
    q16aru_pkg::mode_t  mode_reg, mode_next;

    logic signed [31:0] a_reg, a_next;
    logic [31:0] r_reg, r_next;
    logic [4:0]  bitpos_reg, bitpos_next;
    logic [31:0] mc_reg, mc_next;
    logic [31:0] mp_reg, mp_next;
    logic [63:0] acc_reg, acc_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        dz_reg, dz_next;
    logic [31:0] res_reg, res_next;
    logic        rdz_reg, rdz_next;
    logic        ov_reg, ov_next;

    logic [2:0]  in_op;
    logic [31:0] in_a, in_b, mag_a, mag_b;
    logic        in_acc, out_free;
    logic [32:0] mul_sum, div_sh, div_sub;
    logic        div_ge;
    logic [31:0] q_fin;
    logic [63:0] prod;
    logic signed [31:0] sq;
    logic [31:0] mres, cand, bitval;
    logic        keep;

    assign in_op   = s_axis_tdata[2:0];
    assign in_a    = s_axis_tdata[34:3];
    assign in_b    = s_axis_tdata[66:35];
    assign mag_a   = in_a[31] ? (32'd0 - in_a) : in_a;
    assign mag_b   = in_b[31] ? (32'd0 - in_b) : in_b;
    assign s_axis_tready = (state_reg == q16aru_pkg::ST_IDLE);
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_free = !ov_reg || m_axis_tready;

    assign mul_sum = {1'b0, acc_reg[63:32]} + (mp_reg[0] ? {1'b0, mc_reg} : 33'd0);
    assign div_sh  = {acc_reg[31:0], 1'b1};
    assign div_ge  = div_sh >= {1'b0, mc_reg};
    assign div_sub = div_sh - {1'b0, mc_reg};
    assign q_fin   = {mp_reg[30:0], div_ge} + 32'd1;

    assign prod    = (neg_reg && mode_reg != q16aru_pkg::MODE_DIV) ? (64'd0 - acc_reg) : acc_reg;
    assign sq      = prod[FRAC_BITS+31 -: 32];
    assign bitval  = 32'(1) << bitpos_reg;
    assign cand    = r_reg ^ bitval;
    assign keep    = (mode_reg == q16aru_pkg::MODE_SQLO) ? (sq >= a_reg)
                   : (sq >= 0 && sq <= a_reg);

    always_comb
    begin
        if (mode_reg == q16aru_pkg::MODE_DIV)
        begin
            mres = acc_reg[63-FRAC_BITS -: 32];
            if (neg_reg)
            begin
                mres = 32'd0 - mres;
            end
        end
        else
        begin
            mres = sq;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            q16aru_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    priority if (in_op == q16aru_pkg::OP_MUL)
                        state_next = q16aru_pkg::ST_MUL;
                    else if (in_op == q16aru_pkg::OP_DIV && in_b != 32'd0)
                        state_next = q16aru_pkg::ST_DIV;
                    else if (in_op == q16aru_pkg::OP_SQRT && $signed(in_a) < $signed(ONE_VAL))
                        state_next = q16aru_pkg::ST_SQTRY;
                    else if (in_op == q16aru_pkg::OP_SQRT && $signed(in_a) > $signed(ONE_VAL))
                        state_next = q16aru_pkg::ST_SQSCAN;
                    else
                        state_next = q16aru_pkg::ST_WRITE;
                end
            end
            q16aru_pkg::ST_DIV:
                if (cnt_reg == 5'd31) state_next = q16aru_pkg::ST_MUL;
            q16aru_pkg::ST_MUL:
                if (cnt_reg == 5'd31) state_next = q16aru_pkg::ST_MFIN;
            q16aru_pkg::ST_MFIN:
            begin
                if ((mode_reg == q16aru_pkg::MODE_SQLO || mode_reg == q16aru_pkg::MODE_SQHI)
                    && bitpos_reg != 5'd0)
                    state_next = q16aru_pkg::ST_SQTRY;
                else
                    state_next = q16aru_pkg::ST_WRITE;
            end
            q16aru_pkg::ST_SQSCAN:
                if (!($signed(bitval) > a_reg)) state_next = q16aru_pkg::ST_SQTRY;
            q16aru_pkg::ST_SQTRY:
                state_next = q16aru_pkg::ST_MUL;
            q16aru_pkg::ST_WRITE:
                if (out_free) state_next = q16aru_pkg::ST_IDLE;
            default:
                state_next = q16aru_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        mode_next   = mode_reg;
        a_next      = a_reg;
        r_next      = r_reg;
        bitpos_next = bitpos_reg;
        mc_next     = mc_reg;
        mp_next     = mp_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        dz_next     = dz_reg;
        res_next    = res_reg;
        rdz_next    = rdz_reg;
        ov_next     = ov_reg && !m_axis_tready;
        unique case (state_reg)
            q16aru_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    dz_next  = 1'b0;
                    r_next   = 32'd0;
                    cnt_next = 5'd0;
                    acc_next = 64'd0;
                    a_next   = $signed(in_a);
                    neg_next = in_a[31] ^ in_b[31];
                    unique case (in_op)
                        q16aru_pkg::OP_ADD: r_next = in_a + in_b;
                        q16aru_pkg::OP_SUB: r_next = in_a - in_b;
                        q16aru_pkg::OP_MUL:
                        begin
                            mode_next = q16aru_pkg::MODE_MUL;
                            mc_next   = mag_a;
                            mp_next   = mag_b;
                        end
                        q16aru_pkg::OP_DIV:
                        begin
                            mode_next = q16aru_pkg::MODE_DIV;
                            dz_next   = (in_b == 32'd0);
                            a_next    = $signed(mag_a);
                            mc_next   = mag_b;
                        end
                        q16aru_pkg::OP_SQRT:
                        begin
                            if ($signed(in_a) < $signed(ONE_VAL))
                            begin
                                mode_next   = q16aru_pkg::MODE_SQLO;
                                r_next      = ONE_VAL - 32'd1;
                                bitpos_next = 5'(FRAC_BITS - 1);
                            end
                            else if ($signed(in_a) > $signed(ONE_VAL))
                            begin
                                mode_next   = q16aru_pkg::MODE_SQHI;
                                bitpos_next = 5'(START_BIT);
                            end
                            else
                            begin
                                r_next = ONE_VAL;
                            end
                        end
                        default: r_next = 32'd0;
                    endcase
                end
            end
            q16aru_pkg::ST_DIV:
            begin
                acc_next = {32'd0, div_ge ? div_sub[31:0] : div_sh[31:0]};
                mp_next  = {mp_reg[30:0], div_ge};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    mc_next  = a_reg;
                    mp_next  = q_fin;
                    acc_next = 64'd0;
                end
            end
            q16aru_pkg::ST_MUL:
            begin
                acc_next = {mul_sum, acc_reg[31:1]};
                mp_next  = {1'b0, mp_reg[31:1]};
                cnt_next = cnt_reg + 5'd1;
            end
            q16aru_pkg::ST_MFIN:
            begin
                if (mode_reg == q16aru_pkg::MODE_SQLO || mode_reg == q16aru_pkg::MODE_SQHI)
                begin
                    if (keep) r_next = cand;
                    if (bitpos_reg != 5'd0) bitpos_next = bitpos_reg - 5'd1;
                end
                else
                begin
                    r_next = mres;
                end
            end
            q16aru_pkg::ST_SQSCAN:
            begin
                if ($signed(bitval) > a_reg) bitpos_next = bitpos_reg - 5'd1;
            end
            q16aru_pkg::ST_SQTRY:
            begin
                mc_next  = cand;
                mp_next  = cand;
                acc_next = 64'd0;
                cnt_next = 5'd0;
                neg_next = 1'b0;
            end
            q16aru_pkg::ST_WRITE:
            begin
                if (out_free)
                begin
                    res_next = r_reg;
                    rdz_next = dz_reg;
                    ov_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= q16aru_pkg::ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        a_reg      <= a_next;
        r_reg      <= r_next;
        bitpos_reg <= bitpos_next;
        mc_reg     <= mc_next;
        mp_reg     <= mp_next;
        acc_reg    <= acc_next;
        cnt_reg    <= cnt_next;
        neg_reg    <= neg_next;
        dz_reg     <= dz_next;
        res_reg    <= res_next;
        rdz_reg    <= rdz_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {7'd0, rdz_reg, res_reg};
endmodule
`default_nettype wire

>>> rtl/q16aru_checker.sv
// Port-level checks for the arithmetic unit, bound to the top level.
`default_nettype none
module q16aru_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result transfer dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while one is in flight");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:33] == 7'd0)
        else $error("padding bits of result not zero");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared one cycle after transfer");
endmodule

bind q16_16_arithmetic_unit q16aru_checker u_q16aru_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
